// ===== src/trcp_pkg.sv =====
// Shared types and constants of the toroidal ring claim painter.
`default_nettype none

package trcp_pkg;

   localparam int GRID_W    = 9;   // width of the grid size registers and coordinates
   localparam int IDX_W     = 18;  // holds row * width + column for any legal grid size
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0]  center_x;
      logic [7:0]  center_y;
      logic [4:0]  radius;
      logic [15:0] color;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_index;
      logic        claimed;
      logic        changed;
      logic        error;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic clear_en;
      logic flush_err;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic reject;
      logic last_access;
      logic pipe_busy;
      logic clear_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/trcp_ctrl.sv =====
// Controller state machine: clearing pass, item acceptance, ring walk and close.
`default_nettype none

module trcp_ctrl
   import trcp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (status.reject) begin
                  cmd.flush_err = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (status.last_access) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The closing result goes out once every access has been checked.
            if (!status.pipe_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== src/trcp_datapath.sv =====
// Datapath: size registers, ring coordinate generator, address pipeline and grid memory.
`default_nettype none

module trcp_datapath
   import trcp_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int COLOR_BITS = 16,
   parameter int MAX_RADIUS = 16
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctrl_cmd_type         cmd,
   output dp_status_type             status,
   input  wire req_type              req_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GRID_W-1:0]    csr_wdata,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data
);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int SUM_W = GRID_W + 1;
   localparam int WCAP  = (MAX_WIDTH  > (2**GRID_W - 1)) ? (2**GRID_W - 1) : MAX_WIDTH;
   localparam int HCAP  = (MAX_HEIGHT > (2**GRID_W - 1)) ? (2**GRID_W - 1) : MAX_HEIGHT;
   localparam logic [GRID_W-1:0] WCAP_V    = GRID_W'(WCAP);
   localparam logic [GRID_W-1:0] HCAP_V    = GRID_W'(HCAP);
   localparam logic [6:0]        MAXR_V    = 7'(MAX_RADIUS);
   localparam logic [AW-1:0]     CLR_LAST  = AW'(CELLS - 1);

   // Size registers.
   logic [GRID_W-1:0] grid_width_ff;
   logic [GRID_W-1:0] grid_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_W'(256);
         grid_height_ff <= GRID_W'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
         endcase
      end
   end

   logic [GRID_W-1:0] w_eff;
   logic [GRID_W-1:0] h_eff;
   assign w_eff = (grid_width_ff  > WCAP_V) ? WCAP_V : grid_width_ff;
   assign h_eff = (grid_height_ff > HCAP_V) ? HCAP_V : grid_height_ff;

   // Acceptance check on the offered item.
   logic [COLOR_BITS-1:0] req_color_m;
   logic [GRID_W-1:0]     req_r9;
   assign req_color_m = COLOR_BITS'(req_data.color);
   assign req_r9      = GRID_W'(req_data.radius);

   assign status.reject = (req_r9 >= w_eff) || (req_r9 >= h_eff) ||
                          ({2'b00, req_data.radius} > MAXR_V) ||
                          (GRID_W'(req_data.center_x) >= w_eff) ||
                          (GRID_W'(req_data.center_y) >= h_eff) ||
                          (req_color_m == '0);

   // Item registers and ring walk counters.
   logic [GRID_W-1:0]     cx_ff;
   logic [GRID_W-1:0]     cy_ff;
   logic [4:0]            r_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic [4:0]            step_ff;
   logic [4:0]            step_in;
   logic [1:0]            corner_ff;
   logic [1:0]            corner_in;

   always_comb begin
      step_in   = step_ff;
      corner_in = corner_ff;
      if (cmd.load) begin
         step_in   = '0;
         corner_in = '0;
      end else if (cmd.issue) begin
         corner_in = corner_ff + 2'd1;
         if (corner_ff == 2'd3) begin
            step_in = step_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         corner_ff <= '0;
      end else begin
         step_ff   <= step_in;
         corner_ff <= corner_in;
      end
      if (cmd.load) begin
         cx_ff    <= GRID_W'(req_data.center_x);
         cy_ff    <= GRID_W'(req_data.center_y);
         r_ff     <= req_data.radius;
         color_ff <= req_color_m;
      end
   end

   assign status.last_access = (step_ff == r_ff) && (corner_ff == 2'd3);

   // Coordinates of the current corner, each wrapped once into the torus.
   logic [SUM_W-1:0] cx10, cy10, i10, r10, w10, h10;
   logic [SUM_W-1:0] xl, xr_s, xr, cyi, yu, yd_s, yd;
   logic [SUM_W-1:0] x_sel, y_sel;

   always_comb begin
      cx10  = SUM_W'(cx_ff);
      cy10  = SUM_W'(cy_ff);
      i10   = SUM_W'(step_ff);
      r10   = SUM_W'(r_ff);
      w10   = SUM_W'(w_eff);
      h10   = SUM_W'(h_eff);
      xl    = (cx10 >= i10) ? (cx10 - i10) : (cx10 + w10 - i10);
      xr_s  = cx10 + i10;
      xr    = (xr_s >= w10) ? (xr_s - w10) : xr_s;
      cyi   = cy10 + i10;
      yu    = (cyi >= r10) ? (cyi - r10) : (cyi + h10 - r10);
      yd_s  = cy10 + r10 - i10;
      yd    = (yd_s >= h10) ? (yd_s - h10) : yd_s;
      // Corner order: left/up, left/down, right/up, right/down.
      x_sel = corner_ff[1] ? xr : xl;
      y_sel = corner_ff[0] ? yd : yu;
   end

   // Address pipeline: coordinates, row base product, read, check.
   logic              v1_ff, v2_ff, v3_ff;
   logic [GRID_W-1:0] x1_ff, y1_ff, x2_ff;
   logic [IDX_W-1:0]  prod_ff;
   logic [IDX_W-1:0]  idx2;
   logic [IDX_W-1:0]  idx3_ff;

   assign idx2 = prod_ff + IDX_W'(x2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      x1_ff   <= x_sel[GRID_W-1:0];
      y1_ff   <= y_sel[GRID_W-1:0];
      prod_ff <= IDX_W'(y1_ff) * IDX_W'(w_eff);
      x2_ff   <= x1_ff;
      idx3_ff <= idx2;
   end

   assign status.pipe_busy = v1_ff || v2_ff || v3_ff;

   // Grid memory with a single write port and a registered read.
   logic [COLOR_BITS-1:0] grid_mem [CELLS];
   logic [COLOR_BITS-1:0] rdata_ff;
   logic [AW-1:0]         clr_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [COLOR_BITS-1:0] mem_wdata;
   logic                  claim;
   logic                  hit;
   logic                  wv_ff;
   logic [IDX_W-1:0]      widx_ff;

   // The read of an access can pass the write of the access just before it,
   // so a claim of the same cell by the access just before it counts as owned.
   assign hit   = wv_ff && (widx_ff == idx3_ff);
   assign claim = v3_ff && (rdata_ff == '0) && !hit;

   assign mem_we    = cmd.clear_en || claim;
   assign mem_waddr = cmd.clear_en ? clr_ff : AW'(idx3_ff);
   assign mem_wdata = cmd.clear_en ? '0 : color_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= grid_mem[AW'(idx2)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         wv_ff  <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            clr_ff <= clr_ff + AW'(1);
         end
         wv_ff <= claim;
      end
      widx_ff <= idx3_ff;
   end

   assign status.clear_last = (clr_ff == CLR_LAST);

   // Results: one claim is held back so that the final one can carry last.
   logic        pend_v_ff, pend_v_in;
   logic [15:0] pend_idx_ff, pend_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   always_comb begin
      pend_v_in    = pend_v_ff;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (cmd.flush_err) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.error = 1'b1;
         rsp_in.last  = 1'b1;
      end else if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.last  = 1'b1;
         if (pend_v_ff) begin
            rsp_in.cell_index = pend_idx_ff;
            rsp_in.claimed    = 1'b1;
            rsp_in.changed    = 1'b1;
         end
         pend_v_in = 1'b0;
      end else if (claim) begin
         if (pend_v_ff) begin
            rsp_valid_in      = 1'b1;
            rsp_in            = '0;
            rsp_in.cell_index = pend_idx_ff;
            rsp_in.claimed    = 1'b1;
         end
         pend_v_in   = 1'b1;
         pend_idx_in = idx3_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== src/toroidal_ring_claim_painter_top.sv =====
// Top level of the toroidal ring claim painter: controller plus datapath.
// One grid cell is checked per cycle against the grid memory,
// behind a three-stage address pipeline.
// A rejected item returns its single error result in the cycle after acceptance.
// After reset the whole grid is cleared one cell a cycle, with busy high;
// results cannot be stalled by the receiver.
`default_nettype none

module toroidal_ring_claim_painter_top
   import trcp_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int COLOR_BITS = 16,
   parameter int MAX_RADIUS = 16
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GRID_W-1:0]    csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   trcp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   trcp_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COLOR_BITS (COLOR_BITS),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // An accepted item either starts a walk or is answered at once with an error.
   a_accept_outcome: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || (rsp_valid && rsp_data.error))
      else $error("accepted item neither started nor rejected");

   // The closing result of an item leaves the block ready for the next one.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("busy still high on closing result");

   // Only a closing claim may report a change.
   a_changed_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.changed |-> rsp_data.last && rsp_data.claimed)
      else $error("changed set on a non-closing or non-claim result");

   // An idle cycle with no new item is followed by no result other than a closing one.
   a_no_rsp_after_idle: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !rsp_valid || rsp_data.last)
      else $error("non-closing result while idle");

endmodule

`default_nettype wire

// ===== dv/tb_toroidal_ring_claim_painter_top.sv =====
// Self-checking testbench of the toroidal ring claim painter: directed table, then random phases.
module tb_toroidal_ring_claim_painter_top
   import trcp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SIDE       = 256;
   localparam int MAX_RAD        = 16;
   localparam int CELL_COUNT     = MAX_SIDE * MAX_SIDE;
   localparam int DRAIN_CYCLES   = 120;
   // The grid clear after reset runs with nothing accepted, and this limit must outlast it.
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int PHASE_ITEMS    = 16;
   localparam int PHASE_COUNT    = 5;

   localparam rsp_type REJECTED =
      '{cell_index: 16'd0, claimed: 1'b0, changed: 1'b0, error: 1'b1, last: 1'b1};
   localparam rsp_type NOTHING_CLAIMED =
      '{cell_index: 16'd0, claimed: 1'b0, changed: 1'b0, error: 1'b0, last: 1'b1};
   localparam rsp_type CORNER_CLAIMED =
      '{cell_index: 16'd0, claimed: 1'b1, changed: 1'b1, error: 1'b0, last: 1'b1};

   typedef struct {
      bit                   is_cfg;
      logic [CSR_IDX_W-1:0] csr_sel;
      logic [GRID_W-1:0]    csr_val;
      req_type              req;
      bit                   typed;
      rsp_type              want;
   } step_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GRID_W-1:0]    csr_wdata;

   // Predictor state: owner of every cell and the two size registers.
   logic [15:0]       cell_owner [0:CELL_COUNT-1];
   logic [GRID_W-1:0] width_reg;
   logic [GRID_W-1:0] height_reg;

   rsp_type      ring_reports[$];
   rsp_type      claim_reports_q[$];
   step_row_type directed_steps[$];
   rsp_type      want_now;
   bit           no_gaps;
   int           mismatches;
   int           n_items;
   int           n_rejected;
   int           n_results;
   int           n_claims;
   int           n_csr_writes;
   int           idle_cycles;

   toroidal_ring_claim_painter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int eff_side(input logic [GRID_W-1:0] v);
      return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
   endfunction

   function automatic void claim_cell(input int x, input int y, input int w,
                                      input logic [15:0] color);
      int      idx;
      rsp_type rep;
      idx = y * w + x;
      if (idx >= CELL_COUNT || cell_owner[idx] != 16'd0) return;
      cell_owner[idx] = color;
      rep = '{cell_index: idx[15:0], claimed: 1'b1, changed: 1'b0, error: 1'b0, last: 1'b0};
      ring_reports.push_back(rep);
   endfunction

   // Walks the diamond corners in order and claims free cells, as the block does.
   function automatic void paint_ring(input req_type r);
      int      w, h, rad, cx, cy, xl, xr, yu, yd;
      rsp_type tail;
      ring_reports.delete();
      w   = eff_side(width_reg);
      h   = eff_side(height_reg);
      rad = r.radius;
      cx  = r.center_x;
      cy  = r.center_y;
      if (rad >= w || rad >= h || rad > MAX_RAD || cx >= w || cy >= h || r.color == 16'd0) begin
         ring_reports.push_back(REJECTED);
         return;
      end
      for (int i = 0; i <= rad; i++) begin
         xl = (cx >= i) ? cx - i : cx + w - i;
         xr = cx + i;
         yu = (cy + i >= rad) ? cy + i - rad : cy + i + h - rad;
         yd = cy + rad - i;
         if (xr >= w) xr -= w;
         if (yd >= h) yd -= h;
         claim_cell(xl, yu, w, r.color);
         claim_cell(xl, yd, w, r.color);
         claim_cell(xr, yu, w, r.color);
         claim_cell(xr, yd, w, r.color);
      end
      if (ring_reports.size() == 0) begin
         ring_reports.push_back(NOTHING_CLAIMED);
      end else begin
         tail = ring_reports.pop_back();
         tail.changed = 1'b1;
         tail.last    = 1'b1;
         ring_reports.push_back(tail);
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly rings that fit the current grid; the rest is raw noise on every field.
   function automatic req_type random_item();
      req_type     r;
      logic [31:0] bits;
      int          w, h, lim, rad_top;
      w   = eff_side(width_reg);
      h   = eff_side(height_reg);
      lim = (w < h) ? w : h;
      if (lim > MAX_RAD + 1) lim = MAX_RAD + 1;
      if (lim > 0 && $urandom_range(0, 99) < 85) begin
         rad_top    = ($urandom_range(0, 3) == 0 || lim < 6) ? lim - 1 : 4;
         r.center_x = 8'($urandom_range(0, w - 1));
         r.center_y = 8'($urandom_range(0, h - 1));
         r.radius   = 5'($urandom_range(0, rad_top));
         r.color    = 16'($urandom_range(1, 65535));
      end else begin
         bits       = $urandom;
         r.center_x = bits[7:0];
         r.center_y = bits[15:8];
         r.radius   = bits[20:16];
         r.color    = 16'($urandom_range(0, 65535));
      end
      return r;
   endfunction

   task automatic issue_item(input req_type r, input bit typed, input rsp_type want);
      int gap;
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      paint_ring(r);
      if (typed) begin
         claim_reports_q.push_back(want);
      end else begin
         foreach (ring_reports[k]) claim_reports_q.push_back(ring_reports[k]);
      end
      n_items++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Registers change only once the block has drained every pending result.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] sel, input logic [GRID_W-1:0] val);
      start <= 1'b0;
      while (claim_reports_q.size() != 0 || busy) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_GRID_WIDTH) width_reg = val;
      else height_reg = val;
      n_csr_writes++;
      @(posedge clock);
   endtask

   function automatic void add_cfg(input logic [CSR_IDX_W-1:0] sel, input int val);
      step_row_type row;
      row = '{is_cfg: 1'b1, csr_sel: sel, csr_val: GRID_W'(val), req: '0, typed: 1'b0,
              want: '0};
      directed_steps.push_back(row);
   endfunction

   function automatic void add_item(input int x, input int y, input int rad, input int color,
                                    input bit typed = 1'b0, input rsp_type want = '0);
      step_row_type row;
      row.is_cfg       = 1'b0;
      row.csr_sel      = CSR_GRID_WIDTH;
      row.csr_val      = '0;
      row.req.center_x = 8'(x);
      row.req.center_y = 8'(y);
      row.req.radius   = 5'(rad);
      row.req.color    = 16'(color);
      row.typed        = typed;
      row.want         = want;
      directed_steps.push_back(row);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         n_results++;
         if (rsp_data.claimed) n_claims++;
         if (rsp_data.error) n_rejected++;
         if (claim_reports_q.size() == 0) begin
            report_mismatch($sformatf("result %p with none outstanding", rsp_data));
         end else begin
            want_now = claim_reports_q.pop_front();
            if (rsp_data.cell_index !== want_now.cell_index)
               report_mismatch($sformatf("cell_index %0d, expected %0d",
                                         rsp_data.cell_index, want_now.cell_index));
            if (rsp_data.claimed !== want_now.claimed)
               report_mismatch($sformatf("claimed %b, expected %b",
                                         rsp_data.claimed, want_now.claimed));
            if (rsp_data.changed !== want_now.changed)
               report_mismatch($sformatf("changed %b, expected %b",
                                         rsp_data.changed, want_now.changed));
            if (rsp_data.error !== want_now.error)
               report_mismatch($sformatf("error %b, expected %b",
                                         rsp_data.error, want_now.error));
            if (rsp_data.last !== want_now.last)
               report_mismatch($sformatf("last %b, expected %b",
                                         rsp_data.last, want_now.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
                  idle_cycles, claim_reports_q.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_GRID_WIDTH;
      csr_wdata <= '0;
      foreach (cell_owner[k]) cell_owner[k] = 16'd0;
      width_reg  = GRID_W'(MAX_SIDE);
      height_reg = GRID_W'(MAX_SIDE);
      no_gaps    = 1'b0;

      // Full-size grid straight after reset: corners, wrap on both axes, rejections.
      add_item(0, 0, 0, 16'hFFFF, 1'b1, CORNER_CLAIMED);
      add_item(0, 0, 0, 16'h0001, 1'b1, NOTHING_CLAIMED);
      add_item(255, 255, 16, 16'h8000);
      add_item(128, 200, 8, 16'h5A5A);
      add_item(255, 0, 15, 16'h0F0F);
      add_item(10, 10, 17, 1, 1'b1, REJECTED);
      add_item(10, 10, 31, 1, 1'b1, REJECTED);
      add_item(10, 10, 3, 0, 1'b1, REJECTED);
      // Smallest grid: only radius zero at the origin is legal.
      add_cfg(CSR_GRID_WIDTH, 1);
      add_cfg(CSR_GRID_HEIGHT, 1);
      add_item(0, 0, 0, 7);
      add_item(0, 0, 1, 7, 1'b1, REJECTED);
      add_item(1, 0, 0, 7, 1'b1, REJECTED);
      add_item(0, 1, 0, 7, 1'b1, REJECTED);
      // A width above the maximum acts as the maximum; three rows force row wrap.
      add_cfg(CSR_GRID_WIDTH, 511);
      add_cfg(CSR_GRID_HEIGHT, 3);
      add_item(255, 2, 2, 16'h1234);
      add_item(0, 0, 3, 1, 1'b1, REJECTED);
      // Narrow grid: left and right corners wrap across the width.
      add_cfg(CSR_GRID_WIDTH, 5);
      add_cfg(CSR_GRID_HEIGHT, 256);
      add_item(5, 0, 0, 1, 1'b1, REJECTED);
      add_item(4, 100, 4, 16'h00FF);
      add_item(2, 40, 4, 16'h0100);
      // Zero width rejects everything.
      add_cfg(CSR_GRID_WIDTH, 0);
      add_item(0, 0, 0, 1, 1'b1, REJECTED);
      // Largest radius that fits a 17 by 17 torus.
      add_cfg(CSR_GRID_WIDTH, 17);
      add_cfg(CSR_GRID_HEIGHT, 17);
      add_item(8, 8, 16, 16'hC3C3);
      add_item(0, 16, 16, 16'h3C3C);
      add_item(16, 0, 0, 2);
      add_cfg(CSR_GRID_WIDTH, 256);
      add_cfg(CSR_GRID_HEIGHT, 300);
      add_item(100, 100, 16, 16'hFFFF);
      add_item(0, 0, 0, 16'hFFFF, 1'b1, NOTHING_CLAIMED);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[k]) begin
         if (directed_steps[k].is_cfg)
            write_csr(directed_steps[k].csr_sel, directed_steps[k].csr_val);
         else
            issue_item(directed_steps[k].req, directed_steps[k].typed, directed_steps[k].want);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin
               write_csr(CSR_GRID_WIDTH, GRID_W'(MAX_SIDE));
               write_csr(CSR_GRID_HEIGHT, GRID_W'(MAX_SIDE));
            end
            1: begin
               write_csr(CSR_GRID_WIDTH, GRID_W'($urandom_range(2, 40)));
               write_csr(CSR_GRID_HEIGHT, GRID_W'($urandom_range(2, 40)));
            end
            2: begin
               write_csr(CSR_GRID_WIDTH, GRID_W'(300));
               write_csr(CSR_GRID_HEIGHT, GRID_W'($urandom_range(17, 64)));
            end
            3: begin
               write_csr(CSR_GRID_WIDTH, GRID_W'($urandom_range(1, MAX_SIDE)));
               write_csr(CSR_GRID_HEIGHT, GRID_W'($urandom_range(1, MAX_SIDE)));
            end
            default: begin
               write_csr(CSR_GRID_WIDTH, GRID_W'(6));
               write_csr(CSR_GRID_HEIGHT, GRID_W'(6));
            end
         endcase
         // One phase runs back to back with no idle cycles from the sender.
         no_gaps = (p == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) issue_item(random_item(), 1'b0, '0);
      end

      start <= 1'b0;
      while (claim_reports_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d items (%0d rejected) under %0d register writes.",
               n_items, n_rejected, n_csr_writes);
      $display("Checked %0d results, %0d of them cell claims; %0d mismatches.",
               n_results, n_claims, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
